// ===== rtl/core/nes_pkg.sv =====
`default_nettype none

package nes_pkg;

  localparam int ID_W      = 5;
  localparam int CD_W      = 32;
  localparam int DELAY_W   = 31;
  localparam int TICK_W    = 18;
  localparam int OP_W      = 2;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 64;

  localparam logic [OP_W-1:0] OP_SCHEDULE = 2'd0;
  localparam logic [OP_W-1:0] OP_CANCEL   = 2'd1;
  localparam logic [OP_W-1:0] OP_ADVANCE  = 2'd2;

  localparam logic signed [CD_W-1:0] HORIZON = 32'sh0004_0000;
  localparam logic [TICK_W-1:0] IDLE_RESET   = 18'd4096;
  localparam logic signed [CD_W-1:0] CD_MIN  = 32'sh8000_0000;

  // broadcast from controller to every cell
  typedef struct packed {
    logic                 load;
    logic [OP_W-1:0]      op;
    logic [ID_W-1:0]      id;
    logic [DELAY_W-1:0]   delay;
    logic [TICK_W-1:0]    elapsed;
    logic                 kill;
    logic [ID_W-1:0]      kill_id;
  } cmd_t;

  // running minimum handed down the chain
  typedef struct packed {
    logic                   valid;
    logic [ID_W-1:0]        id;
    logic signed [CD_W-1:0] cd;
  } cand_t;

endpackage

`default_nettype wire

// ===== rtl/core/nes_cell.sv =====
`default_nettype none

module nes_cell #(
  parameter int INDEX = 0
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire nes_pkg::cmd_t  cmd,
  input  wire nes_pkg::cand_t cand_in,
  output nes_pkg::cand_t     cand_out
);
  import nes_pkg::*;

  localparam bit               MATCH_OK = (INDEX < (1 << ID_W));
  localparam logic [ID_W-1:0]  IDX      = ID_W'(INDEX);

  logic                   armed;
  logic signed [CD_W-1:0] cd;
  logic signed [CD_W:0]   diff;
  logic signed [CD_W-1:0] cd_sat;
  logic                   hit;
  logic                   kill_hit;
  logic                   better;

  assign hit      = MATCH_OK && (cmd.id == IDX);
  assign kill_hit = MATCH_OK && cmd.kill && (cmd.kill_id == IDX);
  assign diff     = {cd[CD_W-1], cd} - {{(CD_W+1-TICK_W){1'b0}}, cmd.elapsed};
  assign cd_sat   = (diff[CD_W] != diff[CD_W-1]) ? CD_MIN : diff[CD_W-1:0];
  assign better   = armed && (!cand_in.valid || (cd < cand_in.cd));

  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= 1'b0;
      cd    <= '0;
    end else begin
      if (cmd.load) begin
        unique case (cmd.op)
          OP_SCHEDULE: begin
            if (hit) begin
              armed <= 1'b1;
              cd    <= {1'b0, cmd.delay};
            end
          end
          OP_CANCEL: begin
            if (hit) armed <= 1'b0;
          end
          OP_ADVANCE: begin
            if (armed) cd <= cd_sat;
          end
          default: begin
          end
        endcase
      end
      if (kill_hit) armed <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_out <= '0;
    end else if (better) begin
      cand_out.valid <= 1'b1;
      cand_out.id    <= IDX;
      cand_out.cd    <= cd;
    end else begin
      cand_out <= cand_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/nes_ctrl.sv =====
`default_nettype none

module nes_ctrl #(
  parameter int NUM_SLOTS = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [nes_pkg::IN_DATA_W-1:0]     s_tdata,
  input  wire logic [nes_pkg::OP_W-1:0]          s_tuser,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [nes_pkg::OUT_DATA_W-1:0]         m_tdata,
  output logic                                   m_tlast,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [nes_pkg::TICK_W-1:0]        cfg_data,
  input  wire nes_pkg::cand_t                    best,
  output nes_pkg::cmd_t                          cmd
);
  import nes_pkg::*;

  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam logic [CW-1:0] CNT_DONE = CW'(NUM_SLOTS);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_SEARCH = 1'b1;

  logic              state;
  logic [CW-1:0]     cnt;
  logic              fire_mode;
  logic [TICK_W-1:0] idle_interval;

  logic              accept;
  logic              out_free;
  logic              done;
  logic              fire_now;
  logic              fin_now;
  logic              near;
  logic [TICK_W-1:0] delta;

  logic              fired;
  logic [ID_W-1:0]   fired_id;
  logic [CD_W-1:0]   lateness;
  logic              next_valid;
  logic [ID_W-1:0]   next_id;
  logic [TICK_W-1:0] next_delta;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign done      = (state == ST_SEARCH) && (cnt == CNT_DONE) && out_free;
  assign fire_now  = done && fire_mode && best.valid && (best.cd <= 0);
  assign fin_now   = done && !fire_now;
  assign near      = best.valid && (best.cd < HORIZON);
  assign delta     = best.cd[CD_W-1] ? '0 : best.cd[TICK_W-1:0];

  assign cmd.load    = accept;
  assign cmd.op      = s_tuser;
  assign cmd.id      = s_tdata[ID_W-1:0];
  assign cmd.delay   = s_tdata[ID_W+DELAY_W-1:ID_W];
  assign cmd.elapsed = s_tdata[ID_W+DELAY_W+TICK_W-1:ID_W+DELAY_W];
  assign cmd.kill    = fire_now;
  assign cmd.kill_id = best.id;

  assign m_tdata = {{(OUT_DATA_W-2*ID_W-CD_W-TICK_W-2){1'b0}},
                    next_delta, next_id, next_valid, lateness, fired_id, fired};

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_interval <= IDLE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      idle_interval <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      fire_mode <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state     <= ST_SEARCH;
            cnt       <= '0;
            fire_mode <= (s_tuser == OP_ADVANCE);
          end
        end
        ST_SEARCH: begin
          if (fire_now) begin
            cnt <= '0;
          end else if (fin_now) begin
            state <= ST_IDLE;
          end else if (cnt != CNT_DONE) begin
            cnt <= cnt + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire_now || fin_now) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_now) begin
      fired      <= 1'b1;
      fired_id   <= best.id;
      lateness   <= best.cd;
      next_valid <= 1'b0;
      next_id    <= '0;
      next_delta <= '0;
      m_tlast    <= 1'b0;
    end else if (fin_now) begin
      fired      <= 1'b0;
      fired_id   <= '0;
      lateness   <= '0;
      next_valid <= near;
      next_id    <= near ? best.id : '0;
      next_delta <= near ? delta : idle_interval;
      m_tlast    <= 1'b1;
    end
  end

`ifndef SYNTH
  a_accept_starts_search: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_SEARCH) && (cnt == '0))
    else $error("search did not restart after accepted request");

  a_fire_restarts: assert property (@(posedge clk) disable iff (rst)
    fire_now |=> (state == ST_SEARCH) && (cnt == '0) && m_tvalid && !m_tlast)
    else $error("fired result not followed by a fresh search");

  a_final_ends_item: assert property (@(posedge clk) disable iff (rst)
    fin_now |=> (state == ST_IDLE) && m_tvalid && m_tlast)
    else $error("final result did not close the request");

  a_fire_only_advance: assert property (@(posedge clk) disable iff (rst)
    fire_now |-> fire_mode && (best.cd <= 0))
    else $error("slot fired outside an advance");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/nearest_event_scheduler.sv =====
`default_nettype none

// Nearest-event scheduler: NUM_SLOTS event slots, each with an armed bit and a
// signed 32-bit countdown, held in a chain of cells that passes the running
// minimum (armed, lowest countdown, lowest index on ties) one cell per cycle.
// s_tuser carries the operation (schedule, cancel, advance); every request ends
// in one m_tlast result with the nearest slot below 0x40000 ticks, or the idle
// interval. An advance first gives one result per expired slot, soonest first.
// One request at a time: s_tready is low until the request's final result is
// produced, and each slot an advance fires restarts the chain search.
// Results wait in an output register; a stalled m_tready holds the search.
module nearest_event_scheduler #(
  parameter int NUM_SLOTS = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // event_id[4:0], delay[35:5], elapsed_ticks[53:36], zero pad
  input  wire logic [nes_pkg::IN_DATA_W-1:0]  s_tdata,
  // operation[1:0]
  input  wire logic [nes_pkg::OP_W-1:0]       s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // fired[0], fired_id[5:1], lateness[37:6], next_valid[38],
  // next_id[43:39], next_delta[61:44], zero pad
  output logic [nes_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic                                m_tlast,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [nes_pkg::TICK_W-1:0]     cfg_data
);
  import nes_pkg::*;

  cmd_t  cmd;
  cand_t link [NUM_SLOTS+1];

  assign link[0] = '0;

  nes_ctrl #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .best      (link[NUM_SLOTS]),
    .cmd       (cmd)
  );

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    nes_cell #(
      .INDEX (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .cand_in  (link[i]),
      .cand_out (link[i+1])
    );
  end

endmodule

`default_nettype wire

// ===== sim/nes_tb_pkg.sv =====
package nes_tb_pkg;
  import nes_pkg::*;

  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
  localparam int SLOT_COUNT = 32;

  typedef struct {
    logic                   fired;
    logic [ID_W-1:0]        fired_id;
    logic signed [CD_W-1:0] lateness;
    logic                   next_valid;
    logic [ID_W-1:0]        next_id;
    logic [TICK_W-1:0]      next_delta;
    logic                   last;
  } sched_result_t;

  class sched_scoreboard;
    bit                     armed[SLOT_COUNT];
    logic signed [CD_W-1:0] countdown[SLOT_COUNT];
    logic [TICK_W-1:0]      idle_interval;
    sched_result_t          due_q[$];
    int unsigned            errors;

    function new();
      idle_interval = IDLE_RESET;
      errors = 0;
      foreach (armed[i]) begin
        armed[i] = 1'b0;
        countdown[i] = '0;
      end
    endfunction

    function void set_idle(logic [TICK_W-1:0] value);
      idle_interval = value;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    // soonest armed slot, lowest index on ties; -1 if none
    function int soonest_slot();
      int best;
      best = -1;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (armed[i] && (best < 0 || countdown[i] < countdown[best])) best = i;
      end
      return best;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                               logic [DELAY_W-1:0] delay, logic [TICK_W-1:0] elapsed);
      sched_result_t r;
      longint        v;
      int            s;
      if (op == OP_SCHEDULE) begin
        countdown[id] = $signed({1'b0, delay});
        armed[id] = 1'b1;
      end else if (op == OP_CANCEL) begin
        armed[id] = 1'b0;
      end else if (op == OP_ADVANCE) begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (armed[i]) begin
            v = longint'(countdown[i]) - longint'(elapsed);
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            countdown[i] = v[CD_W-1:0];
          end
        end
        forever begin
          s = soonest_slot();
          if (s < 0 || countdown[s] > 0) break;
          armed[s] = 1'b0;
          r = '{1'b1, ID_W'(s), countdown[s], 1'b0, '0, '0, 1'b0};
          due_q.push_back(r);
        end
      end
      s = soonest_slot();
      if (s >= 0 && countdown[s] < HORIZON) begin
        r = '{1'b0, '0, '0, 1'b1, ID_W'(s),
              (countdown[s] < 0) ? '0 : countdown[s][TICK_W-1:0], 1'b1};
      end else begin
        r = '{1'b0, '0, '0, 1'b0, '0, idle_interval, 1'b1};
      end
      due_q.push_back(r);
    endfunction

    function void compare(string field, longint want, longint got);
      if (want != got) begin
        errors++;
        $error("%s: expected %0d, got %0d", field, want, got);
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data, logic tlast);
      sched_result_t want;
      if (due_q.size() == 0) begin
        errors++;
        $error("result with none pending: tdata=%h tlast=%b", data, tlast);
        return;
      end
      want = due_q.pop_front();
      compare("fired", want.fired, data[0]);
      compare("fired_id", want.fired_id, data[5:1]);
      compare("lateness", want.lateness, $signed(data[37:6]));
      compare("next_valid", want.next_valid, data[38]);
      compare("next_id", want.next_id, data[43:39]);
      compare("next_delta", want.next_delta, data[61:44]);
      compare("last", want.last, tlast);
    endfunction
  endclass

endpackage

// ===== sim/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import nes_pkg::*;
  import nes_tb_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 3_000_000;
  localparam int LONG_HOLD = 500;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [OP_W-1:0] s_tuser = OP_SCHEDULE;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic m_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [TICK_W-1:0] cfg_data = '0;

  bit tx_gaps_on = 1'b1;
  bit rx_stalls_on = 1'b1;
  bit long_hold_req = 1'b0;
  int unsigned cycle_count = 0;
  sched_scoreboard sb;

  always #5 clk = ~clk;

  nearest_event_scheduler #(.NUM_SLOTS(SLOT_COUNT)) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("** nearest_event_scheduler: FAILED **");
      $finish;
    end
  end

  task automatic send_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                              input logic [DELAY_W-1:0] delay,
                              input logic [TICK_W-1:0] elapsed);
    int unsigned gap;
    gap = tx_gaps_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {2'b00, elapsed, delay, id};
    do @(posedge clk); while (!(s_tvalid && s_tready));
    sb.note_request(op, id, delay, elapsed);
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_idle(input logic [TICK_W-1:0] value);
    s_tvalid <= 1'b0;
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    sb.set_idle(value);
  endtask

  task automatic random_request();
    int unsigned pick;
    int unsigned kind;
    logic [DELAY_W-1:0] delay;
    logic [TICK_W-1:0] ticks;
    pick = $urandom_range(0, 99);
    kind = $urandom_range(0, 9);
    if (pick < 45) begin
      if (kind < 6) delay = DELAY_W'($urandom_range(0, 3000));
      else if (kind < 8) delay = DELAY_W'($urandom_range(32'h3F000, 32'h41000));
      else if (kind < 9) delay = DELAY_W'($urandom());
      else delay = '0;
      send_request(OP_SCHEDULE, ID_W'($urandom()), delay, TICK_W'($urandom()));
    end else if (pick < 60) begin
      send_request(OP_CANCEL, ID_W'($urandom()), DELAY_W'($urandom()),
                   TICK_W'($urandom()));
    end else if (pick < 96) begin
      if (kind < 7) ticks = TICK_W'($urandom_range(0, 1500));
      else if (kind < 9) ticks = TICK_W'($urandom());
      else ticks = '0;
      send_request(OP_ADVANCE, ID_W'($urandom()), DELAY_W'($urandom()), ticks);
    end else begin
      send_request(OP_RESERVED, ID_W'($urandom()), DELAY_W'($urandom()),
                   TICK_W'($urandom()));
    end
  endtask

  // arm every slot close together, then fire them all in one advance
  task automatic fire_all_slots();
    for (int i = 0; i < SLOT_COUNT; i++) begin
      send_request(OP_SCHEDULE, ID_W'(i), DELAY_W'($urandom_range(0, 40)),
                   TICK_W'($urandom()));
    end
    send_request(OP_ADVANCE, ID_W'($urandom()), DELAY_W'($urandom()),
                 TICK_W'($urandom_range(40, 500)));
  endtask

  task automatic random_phase(input int count);
    int burst_at;
    burst_at = $urandom_range(0, count - 1);
    for (int k = 0; k < count; k++) begin
      if (k == burst_at) fire_all_slots();
      else random_request();
    end
  endtask

  initial begin
    logic [TICK_W-1:0] cfg_list[4];
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(OP_ADVANCE, 5'd0, '0, '0);
    send_request(OP_SCHEDULE, 5'd0, '0, '0);
    send_request(OP_ADVANCE, 5'd0, '0, '0);
    send_request(OP_SCHEDULE, 5'd31, 31'h7FFF_FFFF, 18'h3FFFF);
    send_request(OP_SCHEDULE, 5'd5, 31'h3FFFF, '0);
    send_request(OP_SCHEDULE, 5'd6, 31'h40000, '0);
    send_request(OP_SCHEDULE, 5'd7, 31'h3FFFF, '0);
    send_request(OP_SCHEDULE, 5'd5, 31'd100, '0);
    send_request(OP_CANCEL, 5'd9, '0, '0);
    send_request(OP_CANCEL, 5'd7, '0, '0);
    send_request(OP_ADVANCE, 5'd31, 31'h7FFF_FFFF, 18'h3FFFF);
    send_request(OP_SCHEDULE, 5'd2, 31'd50, '0);
    send_request(OP_SCHEDULE, 5'd3, 31'd50, '0);
    send_request(OP_SCHEDULE, 5'd10, 31'd50, '0);
    send_request(OP_ADVANCE, 5'd0, '0, 18'd60);
    send_request(OP_RESERVED, 5'd31, 31'h7FFF_FFFF, 18'h3FFFF);
    send_request(OP_CANCEL, 5'd31, '0, '0);
    send_request(OP_SCHEDULE, 5'd31, 31'd1, '0);
    send_request(OP_ADVANCE, 5'd0, '0, 18'd1);

    cfg_list[0] = 18'h3FFFF;
    cfg_list[1] = 18'd1;
    cfg_list[2] = '0;
    cfg_list[3] = TICK_W'($urandom_range(1, 18'h3FFFF));
    for (int p = 0; p < 4; p++) begin
      write_idle(cfg_list[p]);
      tx_gaps_on = (p != 1) && (p != 3);
      rx_stalls_on = (p != 1) && (p != 2);
      if (p == 1) long_hold_req = 1'b1;
      random_phase(70);
    end

    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** nearest_event_scheduler: PASSED **");
    end else begin
      $display("** nearest_event_scheduler: FAILED **");
    end
    $finish;
  end

  initial begin
    int unsigned wait_cycles;
    while (rst) @(posedge clk);
    forever begin
      wait_cycles = rx_stalls_on ? $urandom_range(0, 14) : 0;
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        wait_cycles = LONG_HOLD;
      end
      if (wait_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      sb.check_result(m_tdata, m_tlast);
    end
  end

endmodule
